/* rtl/core/fdt_pkg.sv */
`default_nettype none

package fdt_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BANDWIDTH     = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_PERIOD = 2'd1;
   localparam logic [1:0] CSR_JUMP_CUTOFF   = 2'd2;

   // Register reset values.
   localparam logic [31:0] BANDWIDTH_RESET     = 32'd65536;
   localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd4294967;
   localparam logic [30:0] JUMP_CUTOFF_RESET   = 31'h7FFF_FFFF;

   // Datapath widths.
   localparam int unsigned ACC_W  = 82;   // signed numerator accumulator
   localparam int unsigned HALF_W = 47;   // w*T/2 in unsigned Q15.32
   localparam int unsigned DEN_W  = 48;   // denominator 1 + w*T/2
   localparam int unsigned QUO_W  = 33;   // quotient bits produced by the divider

   typedef logic [ACC_W-1:0] acc_type;

endpackage : fdt_pkg

`default_nettype wire

/* rtl/core/filtered_derivative_tustin.sv */
// One sample at a time: a new sample is accepted only once the previous result has
// been handed to the output register. Each sample runs the cutoff check, four passes
// through the shared 32x32 multiplier, the 33-step restoring divider and rounding; a
// saturating quotient skips the divider, and a jump goes straight to the hand-over.
// Reset (synchronous, active high) restores the register defaults and clears the
// stored sample and output history.
`default_nettype none

module filtered_derivative_tustin
   import fdt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic signed [31:0] req_sample,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_derivative,
   output      logic               rsp_jump_seen,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   // Sequencer codes.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_MUL1  = 4'd2;
   localparam logic [3:0] ST_MUL2  = 4'd3;
   localparam logic [3:0] ST_MUL3  = 4'd4;
   localparam logic [3:0] ST_ACC   = 4'd5;
   localparam logic [3:0] ST_ABS   = 4'd6;
   localparam logic [3:0] ST_OVF   = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_ROUND = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   localparam logic [5:0] DIV_LAST = 6'(QUO_W - 1);

   logic [3:0]         state_ff, state_in;
   logic [31:0]        bandwidth_ff, bandwidth_in;
   logic [31:0]        period_ff, period_in;
   logic [30:0]        cutoff_ff, cutoff_in;
   logic [31:0]        prev_sample_ff, prev_sample_in;
   logic [31:0]        prev_output_ff, prev_output_in;
   logic               du_neg_ff, du_neg_in;
   logic [32:0]        adu_ff, adu_in;
   logic [63:0]        prod_ff, prod_in;
   logic [HALF_W-1:0]  h_ff, h_in;
   acc_type            acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               sat_ff, sat_in;
   logic               jump_ff, jump_in;
   acc_type            rem_ff, rem_in;
   acc_type            dsh_ff, dsh_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [5:0]         count_ff, count_in;
   logic [31:0]        y_ff, y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_derivative_ff, rsp_derivative_in;
   logic               rsp_jump_ff, rsp_jump_in;

   logic [31:0]        mul_a, mul_b;
   logic [32:0]        du;
   logic [31:0]        y_mag;
   logic [DEN_W-1:0]   den;
   acc_type            y_shift;
   acc_type            t1;
   acc_type            p_lo;
   acc_type            p_hi;
   logic [QUO_W:0]     q_round;
   logic [QUO_W:0]     limit;
   logic [QUO_W:0]     mag;
   logic               accept;
   logic               deliver;

   assign accept  = req_valid && req_ready;
   assign deliver = !rsp_valid_ff || rsp_ready;

   // Operands derived from stored state.
   always_comb begin
      du      = {req_sample[31], req_sample} - {prev_sample_ff[31], prev_sample_ff};
      y_mag   = prev_output_ff[31] ? (32'd0 - prev_output_ff) : prev_output_ff;
      den     = {1'b1, 32'd0} + {1'b0, h_ff};
      y_shift = {{(ACC_W - 64){prev_output_ff[31]}}, prev_output_ff, 32'd0};
      t1      = {{(ACC_W - 80){1'b0}}, prod_ff, 16'd0};
      p_lo    = {{(ACC_W - 64){1'b0}}, prod_ff};
      p_hi    = {{(ACC_W - 80){1'b0}}, prod_ff[47:0], 32'd0};
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (state_ff)
         ST_CHECK: begin
            mul_a = bandwidth_ff;
            mul_b = period_ff;
         end
         ST_MUL1: begin
            mul_a = bandwidth_ff;
            mul_b = adu_ff[31:0];
         end
         ST_MUL2: begin
            mul_a = h_ff[31:0];
            mul_b = y_mag;
         end
         ST_MUL3: begin
            mul_a = {17'd0, h_ff[HALF_W-1:32]};
            mul_b = y_mag;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // Rounding and saturation of the quotient.
   always_comb begin
      q_round = {1'b0, quo_ff} +
                (({rem_ff[DEN_W-1:0], 1'b0} >= {1'b0, den}) ? 34'd1 : 34'd0);
      limit   = neg_ff ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
      mag     = (sat_ff || (q_round > limit)) ? limit : q_round;
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in          = state_ff;
      bandwidth_in      = bandwidth_ff;
      period_in         = period_ff;
      cutoff_in         = cutoff_ff;
      prev_sample_in    = prev_sample_ff;
      prev_output_in    = prev_output_ff;
      du_neg_in         = du_neg_ff;
      adu_in            = adu_ff;
      h_in              = h_ff;
      acc_in            = acc_ff;
      neg_in            = neg_ff;
      sat_in            = sat_ff;
      jump_in           = jump_ff;
      rem_in            = rem_ff;
      dsh_in            = dsh_ff;
      quo_in            = quo_ff;
      count_in          = count_ff;
      y_in              = y_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_derivative_in = rsp_derivative_ff;
      rsp_jump_in       = rsp_jump_ff;

      // Configuration writes; indexes beyond the list are ignored.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BANDWIDTH:     bandwidth_in = csr_wdata;
            CSR_SAMPLE_PERIOD: period_in    = csr_wdata;
            CSR_JUMP_CUTOFF:   cutoff_in    = csr_wdata[30:0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               du_neg_in      = du[32];
               adu_in         = du[32] ? (33'd0 - du) : du;
               prev_sample_in = req_sample;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // A step beyond the cutoff drops the history.
            if (adu_ff > {2'b00, cutoff_ff}) begin
               jump_in  = 1'b1;
               y_in     = 32'd0;
               state_in = ST_DONE;
            end else begin
               jump_in  = 1'b0;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            h_in     = prod_ff[63:17];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // Bandwidth times step, plus the 2^32 * y_prev part of the numerator.
            acc_in   = du_neg_ff ? (y_shift - t1) : (y_shift + t1);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            acc_in   = prev_output_ff[31] ? (acc_ff + p_lo) : (acc_ff - p_lo);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = prev_output_ff[31] ? (acc_ff + p_hi) : (acc_ff - p_hi);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = acc_ff[ACC_W-1];
            rem_in   = acc_ff[ACC_W-1] ? (acc_type'(0) - acc_ff) : acc_ff;
            dsh_in   = {{(ACC_W - DEN_W - 32){1'b0}}, den, 32'd0};
            state_in = ST_OVF;
         end
         ST_OVF: begin
            // A quotient of 2^33 or more always saturates.
            sat_in   = rem_ff >= {dsh_ff[ACC_W-2:0], 1'b0};
            quo_in   = '0;
            count_in = DIV_LAST;
            state_in = (rem_ff >= {dsh_ff[ACC_W-2:0], 1'b0}) ? ST_ROUND : ST_DIV;
         end
         ST_DIV: begin
            // One restoring step per cycle against the shifted denominator.
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dsh_in   = {1'b0, dsh_ff[ACC_W-1:1]};
            count_in = count_ff - 6'd1;
            if (count_ff == 6'd0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            y_in     = neg_ff ? (32'd0 - mag[31:0]) : mag[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (deliver) begin
               rsp_valid_in      = 1'b1;
               rsp_derivative_in = y_ff;
               rsp_jump_in       = jump_ff;
               prev_output_in    = y_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         bandwidth_ff   <= BANDWIDTH_RESET;
         period_ff      <= SAMPLE_PERIOD_RESET;
         cutoff_ff      <= JUMP_CUTOFF_RESET;
         prev_sample_ff <= 32'd0;
         prev_output_ff <= 32'd0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         bandwidth_ff   <= bandwidth_in;
         period_ff      <= period_in;
         cutoff_ff      <= cutoff_in;
         prev_sample_ff <= prev_sample_in;
         prev_output_ff <= prev_output_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      du_neg_ff         <= du_neg_in;
      adu_ff            <= adu_in;
      prod_ff           <= prod_in;
      h_ff              <= h_in;
      acc_ff            <= acc_in;
      neg_ff            <= neg_in;
      sat_ff            <= sat_in;
      jump_ff           <= jump_in;
      rem_ff            <= rem_in;
      dsh_ff            <= dsh_in;
      quo_ff            <= quo_in;
      count_ff          <= count_in;
      y_ff              <= y_in;
      rsp_derivative_ff <= rsp_derivative_in;
      rsp_jump_ff       <= rsp_jump_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_derivative = rsp_derivative_ff;
   assign rsp_jump_seen  = rsp_jump_ff;

   // A jump always reports a zero derivative.
   a_jump_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jump_seen |-> rsp_derivative == 32'd0)
      else $error("jump transaction carries a nonzero derivative");

   // The divider remainder stays below twice the shifted denominator.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < {dsh_ff[ACC_W-2:0], 1'b0})
      else $error("divider remainder out of range");

   // The step counter stays below the quotient length while dividing.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> count_ff <= DIV_LAST)
      else $error("divider step count out of range");

   // An accepted transaction starts the cutoff check in the next cycle.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted transaction did not start processing");

endmodule : filtered_derivative_tustin

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fdt_pkg::*;

   // Writes to this index land on no register and must be ignored.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 48;

   typedef struct packed {
      logic signed [31:0] derivative;
      logic               jump_seen;
   } derivative_result_type;

   // Predicts the filter output for each accepted sample and checks results in order.
   class derivative_scoreboard;
      logic [31:0]             bandwidth;
      logic [31:0]             sample_period;
      logic [30:0]             jump_cutoff;
      logic signed [31:0]      last_sample;
      logic signed [31:0]      last_output;
      derivative_result_type   pending_q[$];
      int                      errors;

      function new();
         bandwidth     = BANDWIDTH_RESET;
         sample_period = SAMPLE_PERIOD_RESET;
         jump_cutoff   = JUMP_CUTOFF_RESET;
         last_sample   = '0;
         last_output   = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_BANDWIDTH:     bandwidth = data;
            CSR_SAMPLE_PERIOD: sample_period = data;
            CSR_JUMP_CUTOFF:   jump_cutoff = data[30:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // Computes the Tustin update for one sample and queues the expected result.
      function void note_sample(logic signed [31:0] sample);
         longint                  step;
         longint                  step_mag;
         logic [63:0]             half_prod;
         logic [127:0]            half;
         logic [127:0]            denom;
         logic [127:0]            mag;
         logic [127:0]            quot;
         logic [127:0]            remain;
         logic [127:0]            lim;
         logic [127:0]            sat;
         logic signed [127:0]     gain;
         logic signed [127:0]     dstep;
         logic signed [127:0]     coef;
         logic signed [127:0]     yprev;
         logic signed [127:0]     numer;
         logic                    neg;
         derivative_result_type   r;

         step     = longint'(sample) - longint'(last_sample);
         step_mag = (step < 0) ? -step : step;
         if (step_mag > longint'(jump_cutoff)) begin
            // A discontinuity drops the history and reports zero.
            r.derivative = '0;
            r.jump_seen  = 1'b1;
            last_sample  = sample;
            last_output  = '0;
         end else begin
            half_prod = {32'b0, bandwidth} * {32'b0, sample_period};
            half      = 128'(half_prod >> 17);
            denom     = (128'd1 << 32) + half;
            gain      = $signed({80'b0, bandwidth, 16'b0});
            dstep     = step;
            coef      = $signed(half) - $signed(128'd1 << 32);
            yprev     = last_output;
            numer     = gain * dstep - coef * yprev;

            // Round half away from zero on the magnitude, then saturate.
            neg    = (numer < 0);
            mag    = neg ? -numer : numer;
            quot   = mag / denom;
            remain = mag % denom;
            if ((remain << 1) >= denom) begin
               quot = quot + 128'd1;
            end
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            sat = (quot > lim) ? lim : quot;
            r.derivative = neg ? (32'd0 - sat[31:0]) : sat[31:0];
            r.jump_seen  = 1'b0;
            last_sample  = sample;
            last_output  = r.derivative;
         end
         pending_q.push_back(r);
      endfunction

      function void check_result(logic signed [31:0] derivative, logic jump_seen);
         derivative_result_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result, derivative %0d jump_seen %0b",
                     $time, derivative, jump_seen);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (derivative !== want.derivative) begin
            $display("%0t: derivative expected %0d, actual %0d",
                     $time, want.derivative, derivative);
            errors++;
         end
         if (jump_seen !== want.jump_seen) begin
            $display("%0t: jump_seen expected %0b, actual %0b",
                     $time, want.jump_seen, jump_seen);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_derivative;
   logic               rsp_jump_seen;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = CSR_BANDWIDTH;
   logic [31:0]        csr_wdata = '0;

   derivative_scoreboard sb;
   logic               idle_on = 1'b1;
   int unsigned        stall_left = 0;
   int unsigned        cycle_count = 0;
   logic signed [31:0] last_sent = '0;
   logic [30:0]        cutoff_now = JUMP_CUTOFF_RESET;

   filtered_derivative_tustin u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_derivative (rsp_derivative),
      .rsp_jump_seen  (rsp_jump_seen),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Result side: check each transaction and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_derivative, rsp_jump_seen);
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("filtered_derivative_tustin: mismatch");
         $finish;
      end
   end

   // Offers one sample, after an optional gap, and holds it until accepted.
   task automatic send_sample(input logic signed [31:0] sample);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(sample);
      last_sent = sample;
   endtask

   task automatic send_list(input logic signed [31:0] samples[$]);
      foreach (samples[i]) send_sample(samples[i]);
   endtask

   // Waits until every expected result has arrived and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // Writes all registers, plus a stray write to the unused index.
   task automatic configure(input logic [31:0] bw, input logic [31:0] period,
                            input logic [31:0] cutoff);
      write_csr(CSR_BANDWIDTH, bw);
      write_csr(CSR_SAMPLE_PERIOD, period);
      write_csr(CSR_JUMP_CUTOFF, cutoff);
      write_csr(CSR_UNUSED, $urandom);
      csr_wr_en <= 1'b0;
      cutoff_now = cutoff[30:0];
   endtask

   function automatic logic [31:0] pick_bandwidth();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return BANDWIDTH_RESET;
         3: return $urandom_range(1, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return SAMPLE_PERIOD_RESET;
         3: return $urandom_range(1, 1 << 24);
         default: return $urandom;
      endcase
   endfunction

   // Bit 31 is random so the register width truncation is exercised.
   function automatic logic [31:0] pick_cutoff();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF | {1'($urandom_range(0, 1)), 31'b0};
         1: return {1'($urandom_range(0, 1)), 31'b0};
         2: return $urandom_range(0, 1 << 24);
         3: return $urandom_range(1 << 16, 1 << 28);
         default: return $urandom;
      endcase
   endfunction

   // Mostly continuous steps of varied size, some at the cutoff edge, some noise, some extremes.
   function automatic logic signed [31:0] pick_sample();
      longint      target;
      int unsigned mode;
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
         target = longint'(last_sent) + (longint'($signed($urandom)) >>> $urandom_range(1, 31));
      end else if (mode < 80) begin
         target = longint'(cutoff_now) + $urandom_range(0, 1);
         target = ($urandom_range(0, 1) == 1) ? longint'(last_sent) + target
                                              : longint'(last_sent) - target;
      end else if (mode < 92) begin
         return $urandom;
      end else begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return last_sent;
         endcase
      end
      if (target > 64'sd2147483647) target = 64'sd2147483647;
      if (target < -64'sd2147483648) target = -64'sd2147483648;
      return target[31:0];
   endfunction

   initial begin
      logic signed [31:0] samples[$];
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: extremes of the sample and jumps past the widest cutoff.
      samples = '{32'sh0, 32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sh0000_0001};
      send_list(samples);
      settle();

      // Huge gain with tiny period drives the quotient into both rails.
      configure(32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF);
      samples = '{32'sh0, 32'sh4000_0000, 32'sh0, 32'sh0000_0001, 32'shFFFF_FFFF};
      send_list(samples);
      settle();

      // Zero bandwidth holds the output; zero cutoff flags any change.
      configure(32'd0, 32'hFFFF_FFFF, 32'd0);
      samples = '{32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'shFFFF_FFFF};
      send_list(samples);
      settle();

      // Steps one past and exactly at the cutoff.
      configure(BANDWIDTH_RESET, 32'hFFFF_FFFF, 32'h0001_0000);
      samples = '{32'sh0001_0000, 32'sh0002_0001, 32'sh0001_0001, 32'sh0};
      send_list(samples);
      settle();

      // Random settings after a first phase at the widest values; the fifth and final phases run idle-free.
      for (int phase = 0; phase < 10; phase++) begin
         idle_on = (phase != 4) && (phase != 9);
         if (phase == 0) begin
            configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
         end else begin
            configure(pick_bandwidth(), pick_period(), pick_cutoff());
         end
         for (int n = 0; n < 100; n++) begin
            send_sample(pick_sample());
         end
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("filtered_derivative_tustin: match");
      end else begin
         $display("filtered_derivative_tustin: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
